// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/sxbc_pkg.sv
// ---------------------------------------------------------------------------
// sxbc_pkg
// constants, substitution boxes and word helpers of the 32-bit
// substitution / key-xor block cipher
// ---------------------------------------------------------------------------
`default_nettype none

package sxbc_pkg;

  localparam int BlockWidth = 32;
  localparam int RoundCount = 18;
  localparam int KeyWords   = 18;

  typedef logic [7:0] sbox_t [256];
  typedef logic [BlockWidth-1:0] rk_base_t [KeyWords];

  // mode codes
  localparam logic KindEncrypt = 1'b0;
  localparam logic KindDecrypt = 1'b1;

  // control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic kind;
  } stage_ctrl_t;

  localparam rk_base_t RkBase = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344, 32'hA4093822, 32'h299F31D0,
    32'h082EFA98, 32'hEC4E6C89, 32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
    32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917, 32'h9216D5D9, 32'h8979FB1B
  };

  localparam sbox_t BoxA = '{
    8'hA9, 8'h67, 8'hB3, 8'hE8, 8'h04, 8'hFD, 8'hA3, 8'h76,
    8'h9A, 8'h92, 8'h80, 8'h78, 8'hE4, 8'hDD, 8'hD1, 8'h38,
    8'h0D, 8'hC6, 8'h35, 8'h98, 8'h18, 8'hF7, 8'hEC, 8'h6C,
    8'h43, 8'h75, 8'h37, 8'h26, 8'hFA, 8'h13, 8'h94, 8'h48,
    8'hF2, 8'hD0, 8'h8B, 8'h30, 8'h84, 8'h54, 8'hDF, 8'h23,
    8'h19, 8'h5B, 8'h3D, 8'h59, 8'hF3, 8'hAE, 8'hA2, 8'h82,
    8'h63, 8'h01, 8'h83, 8'h2E, 8'hD9, 8'h51, 8'h9B, 8'h7C,
    8'hA6, 8'hEB, 8'hA5, 8'hBE, 8'h16, 8'h0C, 8'hE3, 8'h61,
    8'hC0, 8'h8C, 8'h3A, 8'hF5, 8'h73, 8'h2C, 8'h25, 8'h0B,
    8'hBB, 8'h4E, 8'h89, 8'h6B, 8'h53, 8'h6A, 8'hB4, 8'hF1,
    8'hE1, 8'hE6, 8'hBD, 8'h45, 8'hE2, 8'hF4, 8'hB6, 8'h66,
    8'hCC, 8'h95, 8'h03, 8'h56, 8'hD4, 8'h1C, 8'h1E, 8'hD7,
    8'hFB, 8'hC3, 8'h8E, 8'hB5, 8'hE9, 8'hCF, 8'hBF, 8'hBA,
    8'hEA, 8'h77, 8'h39, 8'hAF, 8'h33, 8'hC9, 8'h62, 8'h71,
    8'h81, 8'h79, 8'h09, 8'hAD, 8'h24, 8'hCD, 8'hF9, 8'hD8,
    8'hE5, 8'hC5, 8'hB9, 8'h4D, 8'h44, 8'h08, 8'h86, 8'hE7,
    8'hA1, 8'h1D, 8'hAA, 8'hED, 8'h06, 8'h70, 8'hB2, 8'hD2,
    8'h41, 8'h7B, 8'hA0, 8'h11, 8'h31, 8'hC2, 8'h27, 8'h90,
    8'h20, 8'hF6, 8'h60, 8'hFF, 8'h96, 8'h5C, 8'hB1, 8'hAB,
    8'h9E, 8'h9C, 8'h52, 8'h1B, 8'h5F, 8'h93, 8'h0A, 8'hEF,
    8'h91, 8'h85, 8'h49, 8'hEE, 8'h2D, 8'h4F, 8'h8F, 8'h3B,
    8'h47, 8'h87, 8'h6D, 8'h46, 8'hD6, 8'h3E, 8'h69, 8'h64,
    8'h2A, 8'hCE, 8'hCB, 8'h2F, 8'hFC, 8'h97, 8'h05, 8'h7A,
    8'hAC, 8'h7F, 8'hD5, 8'h1A, 8'h4B, 8'h0E, 8'hA7, 8'h5A,
    8'h28, 8'h14, 8'h3F, 8'h29, 8'h88, 8'h3C, 8'h4C, 8'h02,
    8'hB8, 8'hDA, 8'hB0, 8'h17, 8'h55, 8'h1F, 8'h8A, 8'h7D,
    8'h57, 8'hC7, 8'h8D, 8'h74, 8'hB7, 8'hC4, 8'h9F, 8'h72,
    8'h7E, 8'h15, 8'h22, 8'h12, 8'h58, 8'h07, 8'h99, 8'h34,
    8'h6E, 8'h50, 8'hDE, 8'h68, 8'h65, 8'hBC, 8'hDB, 8'hF8,
    8'hC8, 8'hA8, 8'h2B, 8'h40, 8'hDC, 8'hFE, 8'h32, 8'hA4,
    8'hCA, 8'h10, 8'h21, 8'hF0, 8'hD3, 8'h5D, 8'h0F, 8'h00,
    8'h6F, 8'h9D, 8'h36, 8'h42, 8'h4A, 8'h5E, 8'hC1, 8'hE0
  };

  localparam sbox_t BoxB = '{
    8'h75, 8'hF3, 8'hC6, 8'hF4, 8'hDB, 8'h7B, 8'hFB, 8'hC8,
    8'h4A, 8'hD3, 8'hE6, 8'h6B, 8'h45, 8'h7D, 8'hE8, 8'h4B,
    8'hD6, 8'h32, 8'hD8, 8'hFD, 8'h37, 8'h71, 8'hF1, 8'hE1,
    8'h30, 8'h0F, 8'hF8, 8'h1B, 8'h87, 8'hFA, 8'h06, 8'h3F,
    8'h5E, 8'hBA, 8'hAE, 8'h5B, 8'h8A, 8'h00, 8'hBC, 8'h9D,
    8'h6D, 8'hC1, 8'hB1, 8'h0E, 8'h80, 8'h5D, 8'hD2, 8'hD5,
    8'hA0, 8'h84, 8'h07, 8'h14, 8'hB5, 8'h90, 8'h2C, 8'hA3,
    8'hB2, 8'h73, 8'h4C, 8'h54, 8'h92, 8'h74, 8'h36, 8'h51,
    8'h38, 8'hB0, 8'hBD, 8'h5A, 8'hFC, 8'h60, 8'h62, 8'h96,
    8'h6C, 8'h42, 8'hF7, 8'h10, 8'h7C, 8'h28, 8'h27, 8'h8C,
    8'h13, 8'h95, 8'h9C, 8'hC7, 8'h24, 8'h46, 8'h3B, 8'h70,
    8'hCA, 8'hE3, 8'h85, 8'hCB, 8'h11, 8'hD0, 8'h93, 8'hB8,
    8'hA6, 8'h83, 8'h20, 8'hFF, 8'h9F, 8'h77, 8'hC3, 8'hCC,
    8'h03, 8'h6F, 8'h08, 8'hBF, 8'h40, 8'hE7, 8'h2B, 8'hE2,
    8'h79, 8'h0C, 8'hAA, 8'h82, 8'h41, 8'h3A, 8'hEA, 8'hB9,
    8'hE4, 8'h9A, 8'hA4, 8'h97, 8'h7E, 8'hDA, 8'h7A, 8'h17,
    8'h66, 8'h94, 8'hA1, 8'h1D, 8'h3D, 8'hF0, 8'hDE, 8'hB3,
    8'h0B, 8'h72, 8'hA7, 8'h1C, 8'hEF, 8'hD1, 8'h53, 8'h3E,
    8'h8F, 8'h33, 8'h26, 8'h5F, 8'hEC, 8'h76, 8'h2A, 8'h49,
    8'h81, 8'h88, 8'hEE, 8'h21, 8'hC4, 8'h1A, 8'hEB, 8'hD9,
    8'hC5, 8'h39, 8'h99, 8'hCD, 8'hAD, 8'h31, 8'h8B, 8'h01,
    8'h18, 8'h23, 8'hDD, 8'h1F, 8'h4E, 8'h2D, 8'hF9, 8'h48,
    8'h4F, 8'hF2, 8'h65, 8'h8E, 8'h78, 8'h5C, 8'h58, 8'h19,
    8'h8D, 8'hE5, 8'h98, 8'h57, 8'h67, 8'h7F, 8'h05, 8'h64,
    8'hAF, 8'h63, 8'hB6, 8'hFE, 8'hF5, 8'hB7, 8'h3C, 8'hA5,
    8'hCE, 8'hE9, 8'h68, 8'h44, 8'hE0, 8'h4D, 8'h43, 8'h69,
    8'h29, 8'h2E, 8'hAC, 8'h15, 8'h59, 8'hA8, 8'h0A, 8'h9E,
    8'h6E, 8'h47, 8'hDF, 8'h34, 8'h35, 8'h6A, 8'hCF, 8'hDC,
    8'h22, 8'hC9, 8'hC0, 8'h9B, 8'h89, 8'hD4, 8'hED, 8'hAB,
    8'h12, 8'hA2, 8'h0D, 8'h52, 8'hBB, 8'h02, 8'h2F, 8'hA9,
    8'hD7, 8'h61, 8'h1E, 8'hB4, 8'h50, 8'h04, 8'hF6, 8'hC2,
    8'h16, 8'h25, 8'h86, 8'h56, 8'h55, 8'h09, 8'hBE, 8'h91
  };

  // combined forward box, a then b; evaluated at elaboration
  function automatic sbox_t build_fwd_sub();
    sbox_t res;
    for (int v = 0; v < 256; v++) begin
      res[v] = BoxB[BoxA[v]];
    end
    return res;
  endfunction

  // combined inverse box, inverse b then inverse a; evaluated at elaboration
  function automatic sbox_t build_inv_sub();
    sbox_t inv_a;
    sbox_t inv_b;
    sbox_t res;
    for (int v = 255; v >= 0; v--) begin
      inv_a[BoxA[v]] = 8'(v);
      inv_b[BoxB[v]] = 8'(v);
    end
    for (int v = 0; v < 256; v++) begin
      res[v] = inv_a[inv_b[v]];
    end
    return res;
  endfunction

  localparam sbox_t FwdSub = build_fwd_sub();
  localparam sbox_t InvSub = build_inv_sub();

  // byte-wise substitution of a whole word
  function automatic logic [BlockWidth-1:0] fwd_word(input logic [BlockWidth-1:0] w);
    logic [BlockWidth-1:0] res;
    for (int k = 0; k < BlockWidth / 8; k++) begin
      res[k*8 +: 8] = FwdSub[w[k*8 +: 8]];
    end
    return res;
  endfunction

  function automatic logic [BlockWidth-1:0] inv_word(input logic [BlockWidth-1:0] w);
    logic [BlockWidth-1:0] res;
    for (int k = 0; k < BlockWidth / 8; k++) begin
      res[k*8 +: 8] = InvSub[w[k*8 +: 8]];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sxbc_round.sv
// ---------------------------------------------------------------------------
// sxbc_round
// one registered cipher round, forward or inverse by the item's mode
// ---------------------------------------------------------------------------
`default_nettype none

module sxbc_round
  import sxbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire stage_ctrl_t           ctrl_i,
  input  wire logic [BlockWidth-1:0] data_i,
  input  wire logic [BlockWidth-1:0] enc_key_i,
  input  wire logic [BlockWidth-1:0] dec_key_i,
  output stage_ctrl_t                ctrl_o,
  output logic [BlockWidth-1:0]      data_o
);

  logic                  valid_q;
  logic                  kind_q;
  logic [BlockWidth-1:0] data_d;
  logic [BlockWidth-1:0] data_q;

  // encrypt: substitute then key; decrypt: key then inverse substitute
  always_comb begin
    unique case (ctrl_i.kind)
      KindEncrypt: data_d = fwd_word(data_i) ^ enc_key_i;
      KindDecrypt: data_d = inv_word(data_i ^ dec_key_i);
      default:     data_d = data_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_q <= ctrl_i.kind;
      data_q <= data_d;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign ctrl_o.kind  = kind_q;
  assign data_o       = data_q;

endmodule

`default_nettype wire

// File: hdl/sxbc_skid.sv
// ---------------------------------------------------------------------------
// sxbc_skid
// registered output stage with a skid slot, cuts the ready path
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sxbc_skid
  import sxbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [BlockWidth-1:0] in_data_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [BlockWidth-1:0]      out_data_o
);

  logic                  out_valid_q;
  logic [BlockWidth-1:0] out_data_q;
  logic                  skid_valid_q;
  logic [BlockWidth-1:0] skid_data_q;
  logic                  out_free;

  assign in_ready_o = !skid_valid_q;
  assign out_free   = out_ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // skid slot only fills behind a waiting output
  `ASSERT_SAME(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // a taken output drains the skid slot
  `ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && out_ready_i, !skid_valid_q)
  // drained skid transaction shows up unchanged at the output
  `ASSERT_NEXT(a_skid_order, clk_i, rst_ni, skid_valid_q && out_ready_i,
               out_valid_q && out_data_q == $past(skid_data_q))

endmodule

`default_nettype wire

// File: hdl/substitution_xor_block_cipher32.sv
// ---------------------------------------------------------------------------
// substitution_xor_block_cipher32
// 32-bit substitution / key-xor block cipher, fully pipelined
// ---------------------------------------------------------------------------
// One 32-bit block per transaction, encrypted (kind 0) or decrypted (kind 1)
// under the key register. Every round has its own register stage, so a new
// block is taken in every cycle and a result leaves every cycle while the
// output side keeps taking them; a block passes 18 round stages and then the
// output register. The pipeline moves as a whole and stalls only when the
// output register and its skid slot are both full, so in_ready_o is
// registered and never follows out_ready_i in the same cycle. The key is
// written through the cfg channel, which is always ready; write it only
// while no block is in flight. The key resets to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module substitution_xor_block_cipher32
  import sxbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // key write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [BlockWidth-1:0] cfg_cipher_key_i,
  // block input channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  kind_i,
  input  wire logic [BlockWidth-1:0] block_in_i,
  // block output channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [BlockWidth-1:0]      block_out_o
);

  logic [BlockWidth-1:0] cipher_key_q;
  logic                  adv;

  // stage k holds the word after k rounds; entry 0 is the input port
  stage_ctrl_t           ctrl  [RoundCount+1];
  logic [BlockWidth-1:0] data  [RoundCount+1];

  // key register, written whenever the cfg transaction completes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q <= '0;
    end else if (cfg_valid_i) begin
      cipher_key_q <= cfg_cipher_key_i;
    end
  end

  // whole pipeline advances while the output side has room
  assign in_ready_o = adv;

  assign ctrl[0].valid = in_valid_i;
  assign ctrl[0].kind  = kind_i;
  assign data[0]       = block_in_i;

  // round g: encryption uses key word g, decryption runs the words backward
  for (genvar g = 0; g < RoundCount; g++) begin : g_round
    logic [BlockWidth-1:0] enc_key;
    logic [BlockWidth-1:0] dec_key;

    assign enc_key = cipher_key_q ^ RkBase[g];
    assign dec_key = cipher_key_q ^ RkBase[RoundCount-1-g];

    sxbc_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .ctrl_i    (ctrl[g]),
      .data_i    (data[g]),
      .enc_key_i (enc_key),
      .dec_key_i (dec_key),
      .ctrl_o    (ctrl[g+1]),
      .data_o    (data[g+1])
    );
  end

  // output register with skid slot; its ready drives the pipeline advance
  sxbc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ctrl[RoundCount].valid),
    .in_data_i   (data[RoundCount]),
    .in_ready_o  (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (block_out_o)
  );

endmodule

`default_nettype wire
